[hdl/programmable_transition_table_fsm_defines.svh]
// assertion macros shared by the transition table state machine rtl
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef PROGRAMMABLE_TRANSITION_TABLE_FSM_DEFINES_SVH
`define PROGRAMMABLE_TRANSITION_TABLE_FSM_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PTT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ptt check failed");

// next-cycle implication
`define PTT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ptt check failed");

`else

`define PTT_ASSERT_IMP(lbl, ante, cons)
`define PTT_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

[hdl/ptt_pkg.sv]
// types and constants of the transition table state machine
// used by ptt_ctrl, ptt_dp and the top level; no dependencies
package ptt_pkg;

    localparam int unsigned EVENT_W  = 16;
    localparam int unsigned FSTATE_W = 8;
    localparam int unsigned STATUS_W = 2;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_TAKEN   = 2'd0;
    localparam logic [STATUS_W-1:0] STS_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] STS_ADDED   = 2'd2;
    localparam logic [STATUS_W-1:0] STS_FULL    = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic latch;     // capture item, restart scan
        logic scan_run;  // one scan step
        logic write;     // append entry if room
        logic finish;    // load result register
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic empty;
        logic ord_hit;
        logic scan_end;
    } t_sts;

endpackage

[hdl/programmable_transition_table_fsm.sv]
// Programmable table-driven state machine. Add items append transition entries
// (source state or catch-all, event code, target state) to a table of TABLE_DEPTH
// entries held in a single-port-read ram; event items scan the table once, in
// order, taking the first ordinary entry that matches the current state and event,
// or else the first catch-all entry for that event. Each item gives one result.
// An add item passes through ST_ADD, which writes the entry if there is room, and
// then ST_FIN. An event item reads the table one entry per cycle through the ram
// read port, which has a registered read; the scan stops early on an ordinary
// match, and an event on an empty table skips the scan. ST_FIN loads the result
// register only once the output is free, so a waiting result holds the item back.
// The table needs no clearing after reset. A finished result is held in an output
// register until taken, and a new item is accepted while it waits.
// depends on ptt_pkg, ptt_ctrl and ptt_dp
module programmable_transition_table_fsm #(
    parameter int unsigned TABLE_DEPTH = 16,
    parameter int unsigned STATE_BITS  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [7:0] from_state, [8] from_any, [24:9] event_code, [32:25] to_state, [39:33] zero
    input  logic [39:0] i_s_tdata,
    // [0] action
    input  logic [0:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] current_state, [8] used_catch_all, [15:9] zero
    output logic [15:0] o_m_tdata,
    // [1:0] status
    output logic [1:0]  o_m_tuser
);

    import ptt_pkg::*;

    t_cmd                cmd;
    t_sts                sts;
    logic [STATUS_W-1:0] status;
    logic [FSTATE_W-1:0] current_state;
    logic                used_catch_all;

    ptt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_action   (i_s_tuser[0]),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    ptt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .STATE_BITS  (STATE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_action         (i_s_tuser[0]),
        .i_from_state     (i_s_tdata[7:0]),
        .i_from_any       (i_s_tdata[8]),
        .i_event_code     ($signed(i_s_tdata[24:9])),
        .i_to_state       (i_s_tdata[32:25]),
        .o_status         (status),
        .o_current_state  (current_state),
        .o_used_catch_all (used_catch_all)
    );

    assign o_m_tdata = {7'b0, used_catch_all, current_state};
    assign o_m_tuser = status;

endmodule

[hdl/ptt_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module ptt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/ptt_dp.sv]
// datapath: transition table ram, entry count, present state, scan and result registers
// depends on ptt_pkg, ptt_ram and the assertion macro header
`include "programmable_transition_table_fsm_defines.svh"

module ptt_dp #(
    parameter int unsigned TABLE_DEPTH = 16,
    parameter int unsigned STATE_BITS  = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ptt_pkg::t_cmd                      i_cmd,
    output ptt_pkg::t_sts                      o_sts,
    input  logic                               i_action,
    input  logic [ptt_pkg::FSTATE_W-1:0]       i_from_state,
    input  logic                               i_from_any,
    input  logic signed [ptt_pkg::EVENT_W-1:0] i_event_code,
    input  logic [ptt_pkg::FSTATE_W-1:0]       i_to_state,
    output logic [ptt_pkg::STATUS_W-1:0]       o_status,
    output logic [ptt_pkg::FSTATE_W-1:0]       o_current_state,
    output logic                               o_used_catch_all
);

    import ptt_pkg::*;

    localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH > 1 ? TABLE_DEPTH : 2);
    localparam int unsigned ENT_W  = 2 * STATE_BITS + 1 + EVENT_W;
    localparam int unsigned EV_LO  = STATE_BITS + 1;
    localparam int unsigned TGT_LO = STATE_BITS + 1 + EVENT_W;

    logic [CNT_W-1:0]      r_count;
    logic [STATE_BITS-1:0] r_state;
    logic [CNT_W-1:0]      r_addr;
    logic                  r_dvalid;
    logic                  r_dlast;
    logic                  r_hit;
    logic [STATE_BITS-1:0] r_hit_tgt;
    logic                  r_ca_found;
    logic [STATE_BITS-1:0] r_ca_tgt;
    logic                  r_add_ok;

    logic                  r_action;
    logic [STATE_BITS-1:0] r_src;
    logic                  r_any;
    logic [EVENT_W-1:0]    r_ev;
    logic [STATE_BITS-1:0] r_tgt;

    logic [STATUS_W-1:0]   r_out_status;
    logic [FSTATE_W-1:0]   r_out_state;
    logic                  r_out_ca;

    logic [ENT_W-1:0]      rd_data;
    logic [STATE_BITS-1:0] d_src;
    logic                  d_any;
    logic [EVENT_W-1:0]    d_ev;
    logic [STATE_BITS-1:0] d_tgt;
    logic                  match_ord;
    logic                  match_ca;
    logic                  issue;
    logic                  room;
    logic                  we;

    logic [STATUS_W-1:0]   n_status;
    logic [STATE_BITS-1:0] n_state;
    logic                  n_ca;

    assign issue = r_addr < r_count;
    assign room  = r_count < CNT_W'(TABLE_DEPTH);
    assign we    = i_cmd.write && room;

    ptt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata ({r_tgt, r_ev, r_any, r_src}),
        .i_raddr (r_addr[ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    assign d_src = rd_data[STATE_BITS-1:0];
    assign d_any = rd_data[STATE_BITS];
    assign d_ev  = rd_data[EV_LO+EVENT_W-1:EV_LO];
    assign d_tgt = rd_data[ENT_W-1:TGT_LO];

    assign match_ord = !d_any && (d_src == r_state) && (d_ev == r_ev);
    assign match_ca  = d_any && (d_ev == r_ev);

    assign o_sts.empty    = (r_count == '0);
    assign o_sts.ord_hit  = r_dvalid && match_ord;
    assign o_sts.scan_end = r_dvalid && r_dlast;

    // add item: added or full; event: ordinary hit wins, else first catch-all seen in the scan, else ignored
    always_comb begin
        n_state = r_state;
        n_ca    = 1'b0;
        if (!r_action) begin
            n_status = r_add_ok ? STS_ADDED : STS_FULL;
        end else if (r_hit) begin
            n_status = STS_TAKEN;
            n_state  = r_hit_tgt;
        end else if (r_ca_found) begin
            n_status = STS_TAKEN;
            n_state  = r_ca_tgt;
            n_ca     = 1'b1;
        end else begin
            n_status = STS_IGNORED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_state    <= '0;
            r_addr     <= '0;
            r_dvalid   <= 1'b0;
            r_hit      <= 1'b0;
            r_ca_found <= 1'b0;
        end else begin
            if (i_cmd.latch) begin
                r_addr     <= '0;
                r_dvalid   <= 1'b0;
                r_hit      <= 1'b0;
                r_ca_found <= 1'b0;
            end
            if (i_cmd.scan_run) begin
                r_dvalid <= issue;
                if (issue) begin
                    r_addr <= r_addr + CNT_W'(1);
                end
                if (r_dvalid && match_ord) begin
                    r_hit <= 1'b1;
                end
                if (r_dvalid && match_ca && !r_ca_found) begin
                    r_ca_found <= 1'b1;
                end
            end
            if (we) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.finish) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action <= i_action;
            r_src    <= STATE_BITS'(i_from_state);
            r_any    <= i_from_any;
            r_ev     <= i_event_code;
            r_tgt    <= STATE_BITS'(i_to_state);
        end
        if (i_cmd.scan_run) begin
            r_dlast <= (r_addr == r_count - CNT_W'(1));
            if (r_dvalid && match_ord) begin
                r_hit_tgt <= d_tgt;
            end
            if (r_dvalid && match_ca && !r_ca_found) begin
                r_ca_tgt <= d_tgt;
            end
        end
        if (i_cmd.write) begin
            r_add_ok <= room;
        end
        if (i_cmd.finish) begin
            r_out_status <= n_status;
            r_out_state  <= FSTATE_W'(16'(n_state));
            r_out_ca     <= n_ca;
        end
    end

    assign o_status         = r_out_status;
    assign o_current_state  = r_out_state;
    assign o_used_catch_all = r_out_ca;

    `PTT_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(TABLE_DEPTH))
    `PTT_ASSERT_IMP(a_addr_bound, 1'b1, r_addr <= r_count)
    `PTT_ASSERT_IMP(a_scan_nonempty, i_cmd.scan_run, r_count != '0)
    `PTT_ASSERT_IMP(a_hit_on_event, i_cmd.finish && r_hit, r_action)

endmodule

[hdl/ptt_ctrl.sv]
// controller: sequences accept, table append, table scan and result hand-off
// depends on ptt_pkg and the assertion macro header
`include "programmable_transition_table_fsm_defines.svh"

module ptt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic          i_action,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output ptt_pkg::t_cmd o_cmd,
    input  ptt_pkg::t_sts i_sts
);

    import ptt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADD  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] r_st;
    logic [1:0] n_st;
    logic       r_out_valid;
    logic       accept;
    logic       out_free;

    assign o_s_tready = (r_st == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    always_comb begin
        o_cmd = '0;
        n_st  = r_st;
        case (r_st)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.latch = 1'b1;
                    if (!i_action) begin
                        n_st = ST_ADD;
                    end else if (i_sts.empty) begin
                        n_st = ST_FIN;
                    end else begin
                        n_st = ST_SCAN;
                    end
                end
            end
            ST_ADD: begin
                o_cmd.write = 1'b1;
                n_st        = ST_FIN;
            end
            ST_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.ord_hit || i_sts.scan_end) begin
                    n_st = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold until the result register can take the item
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_st         = ST_IDLE;
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;

    `PTT_ASSERT_NXT(a_fin_gives_result, r_st == ST_FIN && out_free, r_out_valid)
    `PTT_ASSERT_IMP(a_scan_only_nonempty, r_st == ST_SCAN, !i_sts.empty)
    `PTT_ASSERT_NXT(a_add_then_fin, r_st == ST_ADD, r_st == ST_FIN)

endmodule

[sim/tb_top.sv]
// testbench for programmable_transition_table_fsm: directed and random add and event items,
// each result checked against an in-bench model of the transition table and current state
// depends on ptt_pkg and programmable_transition_table_fsm
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ptt_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int STATE_BITS   = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;
    localparam int REPORT_MAX   = 10;

    typedef enum logic {
        ACT_ADD   = 1'b0,
        ACT_EVENT = 1'b1
    } t_action;

    typedef struct packed {
        t_action              act;
        logic [FSTATE_W-1:0]  src;
        logic                 any;
        logic [EVENT_W-1:0]   ev;
        logic [FSTATE_W-1:0]  dst;
    } t_fsm_item;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [FSTATE_W-1:0]  state;
        logic                 catch_all;
    } t_fsm_result;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles   = 0;
    int cycle_count   = 0;
    int mismatch_count = 0;

    // model of the block: transition table, entry count and current state
    logic [FSTATE_W-1:0] tbl_source [TABLE_DEPTH];
    logic                tbl_any    [TABLE_DEPTH];
    logic [EVENT_W-1:0]  tbl_event  [TABLE_DEPTH];
    logic [FSTATE_W-1:0] tbl_target [TABLE_DEPTH];
    int                  tbl_count  = 0;
    logic [FSTATE_W-1:0] fsm_state  = '0;

    t_fsm_result expected_results [$];

    programmable_transition_table_fsm #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .STATE_BITS  (STATE_BITS)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_top failed");
            $finish;
        end
    end

    // long output stall, armed by the pressure test
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    always @(negedge clk) begin
        m_tready <= (hold_cycles == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic t_fsm_result advance_fsm_model(t_fsm_item it);
        t_fsm_result r;
        bit          hit;
        r   = '{status: STS_IGNORED, state: '0, catch_all: 1'b0};
        hit = 1'b0;
        if (it.act == ACT_ADD) begin
            if (tbl_count < TABLE_DEPTH) begin
                tbl_source[tbl_count] = it.src;
                tbl_any[tbl_count]    = it.any;
                tbl_event[tbl_count]  = it.ev;
                tbl_target[tbl_count] = it.dst;
                tbl_count++;
                r.status = STS_ADDED;
            end else begin
                r.status = STS_FULL;
            end
        end else begin
            // ordinary entries first, catch-all entries only when none matched
            for (int i = 0; i < tbl_count && !hit; i++) begin
                if (!tbl_any[i] && tbl_source[i] == fsm_state && tbl_event[i] == it.ev) begin
                    fsm_state = tbl_target[i];
                    hit = 1'b1;
                end
            end
            for (int i = 0; i < tbl_count && !hit; i++) begin
                if (tbl_any[i] && tbl_event[i] == it.ev) begin
                    fsm_state   = tbl_target[i];
                    hit         = 1'b1;
                    r.catch_all = 1'b1;
                end
            end
            r.status = hit ? STS_TAKEN : STS_IGNORED;
        end
        r.state = fsm_state;
        return r;
    endfunction

    // mostly small states and events already in the table so that entries get taken
    function automatic t_fsm_item random_fsm_item(int add_pct);
        t_fsm_item it;
        it.act = ($urandom_range(0, 99) < add_pct) ? ACT_ADD : ACT_EVENT;
        it.src = ($urandom_range(0, 9) < 7) ? FSTATE_W'($urandom_range(0, 3))
                                            : FSTATE_W'($urandom);
        it.any = ($urandom_range(0, 3) == 0);
        it.dst = ($urandom_range(0, 9) < 7) ? FSTATE_W'($urandom_range(0, 3))
                                            : FSTATE_W'($urandom);
        if (tbl_count != 0 && $urandom_range(0, 9) < 8) begin
            it.ev = tbl_event[$urandom_range(0, tbl_count - 1)];
        end else begin
            it.ev = EVENT_W'($urandom);
        end
        return it;
    endfunction

    task automatic offer_item(input t_fsm_item it);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, it.dst, it.ev, it.any, it.src};
        s_tuser  <= it.act;
        do @(posedge clk); while (!s_tready);
        expected_results = {expected_results, advance_fsm_model(it)};
    endtask

    always @(posedge clk) begin
        t_fsm_result got;
        t_fsm_result want;
        if (rst_n && m_tvalid && m_tready) begin
            got = '{status: m_tuser, state: m_tdata[7:0], catch_all: m_tdata[8]};
            if (expected_results.size() == 0) begin
                if (mismatch_count < REPORT_MAX) begin
                    $display("unexpected result: status %0d state %0d catch_all %0d",
                             got.status, got.state, got.catch_all);
                end
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.state !== want.state ||
                    got.catch_all !== want.catch_all) begin
                    if (mismatch_count < REPORT_MAX) begin
                        $display("mismatch at cycle %0d: expected status %0d state %0d %s",
                                 cycle_count, want.status, want.state,
                                 $sformatf("catch_all %0d, got status %0d state %0d catch_all %0d",
                                           want.catch_all, got.status, got.state,
                                           got.catch_all));
                    end
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_empty_table();
        offer_item('{ACT_EVENT, 8'd0, 1'b0, 16'h0000, 8'd0});
        offer_item('{ACT_EVENT, 8'd255, 1'b1, 16'hFFFF, 8'd255});
    endtask

    // ordinary entry beats an earlier catch-all, first of duplicates wins
    task automatic test_match_priority();
        offer_item('{ACT_ADD, 8'd0,   1'b0, 16'h8000, 8'd255});
        offer_item('{ACT_ADD, 8'd255, 1'b1, 16'h7FFF, 8'd0});
        offer_item('{ACT_ADD, 8'd255, 1'b0, 16'h7FFF, 8'd170});
        offer_item('{ACT_ADD, 8'd255, 1'b0, 16'h7FFF, 8'd85});
        offer_item('{ACT_ADD, 8'd0,   1'b1, 16'h8000, 8'd1});
        offer_item('{ACT_EVENT, 8'd0, 1'b0, 16'h8000, 8'd0});
        offer_item('{ACT_EVENT, 8'd0, 1'b0, 16'h7FFF, 8'd0});
        offer_item('{ACT_EVENT, 8'd0, 1'b0, 16'h7FFF, 8'd0});
        offer_item('{ACT_EVENT, 8'd0, 1'b0, 16'h1234, 8'd0});
        offer_item('{ACT_EVENT, 8'd0, 1'b0, 16'h8000, 8'd0});
        offer_item('{ACT_EVENT, 8'd0, 1'b0, 16'h8000, 8'd0});
        // code one bit away from a table entry must not match
        offer_item('{ACT_EVENT, 8'd0, 1'b0, 16'h8001, 8'd0});
    endtask

    task automatic test_random_traffic(int n_items, int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (n_items) begin
            offer_item(random_fsm_item((tbl_count < TABLE_DEPTH) ? 35 : 8));
        end
    endtask

    task automatic test_table_full();
        while (tbl_count < TABLE_DEPTH) begin
            offer_item(random_fsm_item(100));
        end
        offer_item('{ACT_ADD, 8'd255, 1'b1, 16'hFFFF, 8'd255});
        offer_item('{ACT_ADD, 8'd0,   1'b0, 16'h0000, 8'd0});
        // last entry is reachable and the rejected adds left no trace
        offer_item('{ACT_EVENT, 8'd0, 1'b0, tbl_event[TABLE_DEPTH-1], 8'd0});
        offer_item('{ACT_EVENT, 8'd0, 1'b0, 16'hFFFF, 8'd0});
    endtask

    // receiver stalls for a long stretch while the sender keeps offering items
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(negedge clk);
        hold_cycles = 300;
        repeat (30) begin
            offer_item(random_fsm_item(8));
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_match_priority();
        test_random_traffic(200, 27, 88);
        test_table_full();
        test_random_traffic(200, 88, 27);
        test_random_traffic(200, 0, 0);
        test_output_stall();

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
